>>> rtl/sojb_pkg.sv
// Shared types, constants and helpers for the sequence-ordered jitter buffer.
package sojb_pkg;

    // Store geometry
    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes carried in the output tuser
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_LATE      = 3'd3;
    localparam logic [2:0] ST_BUFFERING = 3'd4;
    localparam logic [2:0] ST_NODATA    = 3'd5;
    localparam logic [2:0] ST_LOST      = 3'd6;

    // Register indexes on the APB port
    localparam logic [1:0] REG_PREBUF   = 2'd0;
    localparam logic [1:0] REG_MAX_FILL = 2'd1;
    localparam logic [1:0] REG_CIRCULAR = 2'd2;

    // One stored packet descriptor
    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  dur;
        logic [31:0] handle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Logical position to physical slot in the circular store
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW:0] idx);
        logic [AW:0] s;
        s = {1'b0, head} + idx;
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

endpackage

>>> rtl/sojb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sojb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/sequence_ordered_jitter_buffer.sv
// Sequence-ordered jitter buffer: sorted descriptor store in RAM plus jitter estimate.
// Transactions are handled one at a time. A push runs the jitter update first once a send
// time is kept, then drops the oldest entry if the store is full in circular mode, then
// finds its place at the tail, at the head or by a linear scan and shifts later entries up.
// Every entry scanned or moved is one RAM read round trip through a wait state.
// Reset: synchronous, active low; store empty, registers at defaults, no clearing pass.
module sequence_ordered_jitter_buffer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [31:0] seq_id, [39:32] duration_ms, [71:40] payload_handle,
    // [119:72] send_time, [167:120] arrival_time
    input  logic [167:0]  i_s_tdata,
    // [1:0] op
    input  logic [1:0]    i_s_tuser,
    // Result stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [31:0] out_id, [39:32] out_duration_ms, [71:40] out_handle,
    // [103:72] jitter_estimate, [119:104] fill_ms
    output logic [119:0]  o_m_tdata,
    // [2:0] status
    output logic [2:0]    o_m_tuser,
    // APB configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW = sojb_pkg::AW;

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_JA, S_JB, S_JC, S_JD, S_JE, S_FULL, S_PLACE, S_DROP_USE,
        S_TAIL_USE, S_HEAD_USE, S_SCAN_RD, S_SCAN_USE, S_SHIFT_RD, S_SHIFT_WR,
        S_INS, S_POP_USE, S_DONE
    } t_state;

    t_state r_state, r_ret;

    // Configuration
    logic [14:0] r_preb_ms;
    logic [15:0] r_max_fill;
    logic        r_circ;

    // Latched transaction
    logic [31:0] r_id;
    logic [7:0]  r_dur;
    logic [31:0] r_handle;
    logic [47:0] r_send, r_arr;

    // Buffer state
    logic [AW-1:0] r_head;
    logic [AW:0]   r_count;
    logic [15:0]   r_buf;
    logic          r_preb;
    logic          r_await;
    logic [31:0]   r_exp;
    logic [47:0]   r_parr, r_psend;
    logic [31:0]   r_jit;

    // Jitter datapath
    logic [47:0] r_da, r_ds, r_d;
    logic [51:0] r_x, r_diff;
    logic        r_ge;

    // Scan and shift indexes
    logic [AW:0] r_idx, r_pos;

    // RAM access
    logic [AW-1:0]             r_raddr, r_waddr;
    logic                      r_we;
    sojb_pkg::t_entry          r_wdata;
    logic [sojb_pkg::ENTRY_W-1:0] w_rdata_raw;
    sojb_pkg::t_entry          w_rd;

    // Result staging and output
    logic [2:0]   r_st;
    logic [31:0]  r_oid, r_ohd;
    logic [7:0]   r_odur;
    logic [119:0] r_mdata;
    logic [2:0]   r_muser;
    logic         r_mvalid;

    // Combinational helpers
    logic [15:0] w_nominal, w_limit;
    logic        w_full;
    logic [16:0] w_buf_add;
    logic [47:0] w_mag;
    logic [52:0] w_nj_up;
    logic [31:0] w_nj_dn;
    logic [31:0] w_e;

    sojb_ram #(
        .WIDTH (sojb_pkg::ENTRY_W),
        .DEPTH (sojb_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rd = sojb_pkg::t_entry'(w_rdata_raw);

    // Fill limit and full test
    assign w_nominal = {r_preb_ms, 1'b0};
    assign w_limit   = (r_max_fill == 16'd0 || r_max_fill <= w_nominal) ? w_nominal
                                                                       : r_max_fill;
    assign w_full    = (r_buf >= w_limit) || (r_count == (AW+1)'(sojb_pkg::DEPTH));
    assign w_buf_add = {1'b0, r_buf} + {9'd0, r_dur};

    // Jitter arithmetic pieces; the rounding sum needs a carry bit near saturation
    assign w_mag   = r_d[47] ? (~r_d + 48'd1) : r_d;
    assign w_nj_up = {21'd0, r_jit} + {5'd0, r_diff[51:4]};
    assign w_nj_dn = r_jit - {3'd0, 29'(({1'b0, r_diff[31:0]} + 33'd15) >> 4)};

    // Expected id seen by a pop
    assign w_e = r_await ? (w_rd.id - 32'd1) : r_exp;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;
    assign pready     = 1'b1;

    // Register read-back
    always_comb begin
        case (paddr[3:2])
            sojb_pkg::REG_PREBUF:   prdata = {17'd0, r_preb_ms};
            sojb_pkg::REG_MAX_FILL: prdata = {16'd0, r_max_fill};
            sojb_pkg::REG_CIRCULAR: prdata = {31'd0, r_circ};
            default:                prdata = 32'd0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preb_ms  <= 15'd40;
            r_max_fill <= 16'd0;
            r_circ     <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                sojb_pkg::REG_PREBUF:   r_preb_ms  <= pwdata[14:0];
                sojb_pkg::REG_MAX_FILL: r_max_fill <= pwdata[15:0];
                sojb_pkg::REG_CIRCULAR: r_circ     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_buf    <= 16'd0;
            r_preb   <= 1'b1;
            r_await  <= 1'b1;
            r_exp    <= 32'd0;
            r_parr   <= 48'd0;
            r_psend  <= 48'd0;
            r_jit    <= 32'd0;
            r_we     <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (r_mvalid && i_m_tready) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_id     <= i_s_tdata[31:0];
                        r_dur    <= i_s_tdata[39:32];
                        r_handle <= i_s_tdata[71:40];
                        r_send   <= i_s_tdata[119:72];
                        r_arr    <= i_s_tdata[167:120];
                        r_oid    <= 32'd0;
                        r_odur   <= 8'd0;
                        r_ohd    <= 32'd0;
                        r_st     <= sojb_pkg::ST_OK;
                        r_state  <= S_DONE;
                        case (i_s_tuser)
                            sojb_pkg::OP_PUSH: begin
                                if (r_psend != 48'd0) begin
                                    r_state <= S_JA;
                                end else begin
                                    r_parr  <= i_s_tdata[167:120];
                                    r_psend <= i_s_tdata[119:72];
                                    r_state <= S_FULL;
                                end
                            end
                            sojb_pkg::OP_POP: begin
                                if (r_preb) begin
                                    r_st <= sojb_pkg::ST_BUFFERING;
                                end else if (r_count == '0) begin
                                    r_preb <= 1'b1;
                                    r_st   <= sojb_pkg::ST_NODATA;
                                end else begin
                                    r_raddr <= r_head;
                                    r_ret   <= S_POP_USE;
                                    r_state <= S_WAIT;
                                end
                            end
                            sojb_pkg::OP_CLEAR: begin
                                r_count <= '0;
                                r_buf   <= 16'd0;
                                r_await <= 1'b1;
                                r_exp   <= 32'd0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WAIT: r_state <= r_ret;
                // Jitter update over several steps
                S_JA: begin
                    r_da    <= r_arr - r_parr;
                    r_ds    <= r_send - r_psend;
                    r_parr  <= r_arr;
                    r_psend <= r_send;
                    r_state <= S_JB;
                end
                S_JB: begin
                    r_d     <= r_da - r_ds;
                    r_state <= S_JC;
                end
                S_JC: begin
                    r_x     <= {w_mag, 4'd0};
                    r_state <= S_JD;
                end
                S_JD: begin
                    r_ge <= (r_x >= {20'd0, r_jit});
                    if (r_x >= {20'd0, r_jit}) begin
                        r_diff <= r_x - {20'd0, r_jit};
                    end else begin
                        r_diff <= {20'd0, r_jit - r_x[31:0]};
                    end
                    r_state <= S_JE;
                end
                S_JE: begin
                    if (r_ge) begin
                        r_jit <= (w_nj_up[52:32] != '0) ? 32'hFFFF_FFFF : w_nj_up[31:0];
                    end else begin
                        r_jit <= w_nj_dn;
                    end
                    r_state <= S_FULL;
                end
                // Overflow handling
                S_FULL: begin
                    if (w_full && !r_circ) begin
                        r_st    <= sojb_pkg::ST_FULL;
                        r_state <= S_DONE;
                    end else if (w_full && r_count != '0) begin
                        r_exp   <= r_exp + 32'd1;
                        r_raddr <= r_head;
                        r_ret   <= S_DROP_USE;
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_DROP_USE: begin
                    r_buf   <= (r_buf >= {8'd0, w_rd.dur}) ? r_buf - {8'd0, w_rd.dur} : 16'd0;
                    r_head  <= sojb_pkg::phys(r_head, (AW+1)'(1));
                    r_count <= r_count - 1'b1;
                    r_state <= S_PLACE;
                end
                // Find insertion point: tail, head, then linear scan
                S_PLACE: begin
                    if (r_count == '0) begin
                        r_pos   <= r_count;
                        r_idx   <= r_count;
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_raddr <= sojb_pkg::phys(r_head, r_count - 1'b1);
                        r_ret   <= S_TAIL_USE;
                        r_state <= S_WAIT;
                    end
                end
                S_TAIL_USE: begin
                    if (r_id > w_rd.id) begin
                        r_pos   <= r_count;
                        r_idx   <= r_count;
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_raddr <= r_head;
                        r_ret   <= S_HEAD_USE;
                        r_state <= S_WAIT;
                    end
                end
                S_HEAD_USE: begin
                    if (r_id < w_rd.id) begin
                        r_st    <= sojb_pkg::ST_LATE;
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    r_raddr <= sojb_pkg::phys(r_head, r_idx);
                    r_ret   <= S_SCAN_USE;
                    r_state <= S_WAIT;
                end
                S_SCAN_USE: begin
                    if (w_rd.id < r_id) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN_RD;
                    end else if (w_rd.id == r_id) begin
                        r_st    <= sojb_pkg::ST_DUP;
                        r_state <= S_DONE;
                    end else begin
                        r_pos   <= r_idx;
                        r_idx   <= r_count;
                        r_state <= S_SHIFT_RD;
                    end
                end
                // Move entries up one slot from the tail, then write the new one
                S_SHIFT_RD: begin
                    if (r_idx == r_pos) begin
                        r_we    <= 1'b1;
                        r_waddr <= sojb_pkg::phys(r_head, r_pos);
                        r_wdata <= '{id: r_id, dur: r_dur, handle: r_handle};
                        r_count <= r_count + 1'b1;
                        r_buf   <= w_buf_add[16] ? 16'hFFFF : w_buf_add[15:0];
                        r_state <= S_INS;
                    end else begin
                        r_raddr <= sojb_pkg::phys(r_head, r_idx - 1'b1);
                        r_ret   <= S_SHIFT_WR;
                        r_state <= S_WAIT;
                    end
                end
                S_SHIFT_WR: begin
                    r_we    <= 1'b1;
                    r_waddr <= sojb_pkg::phys(r_head, r_idx);
                    r_wdata <= w_rd;
                    r_idx   <= r_idx - 1'b1;
                    r_state <= S_SHIFT_RD;
                end
                S_INS: begin
                    if (r_preb && r_buf >= {1'b0, r_preb_ms}) begin
                        r_preb <= 1'b0;
                    end
                    r_state <= S_DONE;
                end
                // Pop: sequence check on the head entry
                S_POP_USE: begin
                    r_await <= 1'b0;
                    r_exp   <= w_e + 32'd1;
                    if (w_rd.id != w_e + 32'd1) begin
                        r_st <= sojb_pkg::ST_LOST;
                    end else begin
                        r_oid   <= w_rd.id;
                        r_odur  <= w_rd.dur;
                        r_ohd   <= w_rd.handle;
                        r_buf   <= (r_buf >= {8'd0, w_rd.dur}) ? r_buf - {8'd0, w_rd.dur}
                                                                : 16'd0;
                        r_head  <= sojb_pkg::phys(r_head, (AW+1)'(1));
                        r_count <= r_count - 1'b1;
                    end
                    r_state <= S_DONE;
                end
                // Hand the result to the output register
                S_DONE: begin
                    if (!r_mvalid || i_m_tready) begin
                        r_mvalid <= 1'b1;
                        r_mdata  <= {r_buf, r_jit, r_ohd, r_odur, r_oid};
                        r_muser  <= r_st;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Entry count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(sojb_pkg::DEPTH))
        else $error("entry count beyond store depth");

    // Count moves by one at a time, or drops to zero on clear
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |->
            (r_count == $past(r_count) + 1'b1 || r_count == $past(r_count) - 1'b1 ||
             r_count == '0))
        else $error("entry count jumped");

    // Packet fields are zero unless a pop returned ok
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && r_muser != sojb_pkg::ST_OK) |-> (r_mdata[71:0] == 72'd0))
        else $error("packet fields set on non-ok result");

    // RAM writes happen only while inserting
    a_write_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_we |-> (r_state == S_INS || r_state == S_SHIFT_RD))
        else $error("RAM write outside insertion");

endmodule
